/* hdl/seq_pkg.sv */
`default_nettype none
package seq_pkg;
    localparam int NUM_BANDS_DEF   = 10;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COEF_DEPTH      = 64;
    localparam int COEF_AW         = 6;
    localparam int COEF_W          = 32;
    localparam int ACC_W           = 56;
    localparam int FRAC            = 28;
    localparam int ENABLE_BITS     = 10;
    localparam int CFG_AW          = 3;
    localparam int CFG_DW          = 16;

    localparam logic [CFG_AW-1:0] REG_BYTESWAP = 3'd0;
    localparam logic [CFG_AW-1:0] REG_PREAMP   = 3'd1;
    localparam logic [CFG_AW-1:0] REG_BANDEN   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_LGAIN    = 3'd3;
    localparam logic [CFG_AW-1:0] REG_RGAIN    = 3'd4;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_COEF   = 1'b1;

    typedef struct packed {
        logic        byteswap;
        logic [7:0]  preamp;
        logic [9:0]  band_en;
        logic [15:0] lgain;
        logic [15:0] rgain;
    } t_cfg;

    function automatic logic signed [ACC_W-1:0] sat56(input logic signed [ACC_W+3:0] v);
        logic signed [ACC_W+3:0] hi;
        logic signed [ACC_W+3:0] lo;
        begin
            hi = (ACC_W+4)'({1'b0, {(ACC_W-1){1'b1}}});
            lo = -hi - (ACC_W+4)'(1);
            if (v > hi) sat56 = hi[ACC_W-1:0];
            else if (v < lo) sat56 = lo[ACC_W-1:0];
            else sat56 = v[ACC_W-1:0];
        end
    endfunction
endpackage
`default_nettype wire

/* hdl/seq_coef_mem.sv */
`default_nettype none
module seq_coef_mem
    import seq_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [COEF_AW-1:0]        i_waddr,
    input  wire logic signed [COEF_W-1:0]  i_wdata,
    input  wire logic [COEF_AW-1:0]        i_raddr,
    output logic signed [COEF_W-1:0]       o_rdata
);
    logic signed [COEF_W-1:0] r_mem [COEF_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* hdl/seq_delay_mem.sv */
`default_nettype none
module seq_delay_mem
    import seq_pkg::*;
#(
    parameter int DEPTH = (NUM_BANDS_DEF + 1) * 4,
    parameter int AW    = $clog2((NUM_BANDS_DEF + 1) * 4)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [AW-1:0]            i_waddr,
    input  wire logic signed [ACC_W-1:0]  i_wdata,
    input  wire logic [AW-1:0]            i_raddr,
    output logic signed [ACC_W-1:0]       o_rdata
);
    logic signed [ACC_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* hdl/stereo_eq_lowpass_chain.sv */
// channel   dir  tdata (low bit up)                         tuser / tlast
// s_axis    in   left_in[15:0] right_in[31:16] coef_index[37:32]
//                coef_value[69:38] pad                      tuser=cmd, tlast=end_of_block
// m_axis    out  left_out[15:0] right_out[31:16]            tlast=end_of_block_out
// cfg       in   i_cfg_we, i_cfg_addr, i_cfg_wdata
// A sample pair walks both channels through one shared multiply-accumulate
// sequencer, band by band with disabled bands skipped and the lowpass stage last,
// so a new pair is taken only once the last pair is through. After reset a clearing
// pass zeroes the coefficient and delay memories; no beat is taken meanwhile. A
// coefficient beat is written to memory as it is accepted. Input is taken only when
// idle; a pending output holds the final state until taken.
`default_nettype none
module stereo_eq_lowpass_chain
    import seq_pkg::*;
#(
    parameter int NUM_BANDS   = NUM_BANDS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [71:0]        s_axis_tdata,  // left_in, right_in, coef_index, coef_value
    input  wire logic               s_axis_tuser,  // cmd
    input  wire logic               s_axis_tlast,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [31:0]             m_axis_tdata,  // left_out, right_out
    output logic                    m_axis_tlast,
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_AW-1:0]  i_cfg_addr,
    input  wire logic [CFG_DW-1:0]  i_cfg_wdata
);
    localparam int STAGES = NUM_BANDS + 1;
    localparam int DDEPTH = STAGES * 4;
    localparam int DAW    = $clog2(DDEPTH);
    localparam int SW     = $clog2(STAGES + 1);
    localparam int CLR_N  = (COEF_DEPTH > DDEPTH) ? COEF_DEPTH : DDEPTH;
    localparam int CLR_W  = $clog2(CLR_N + 1);

    localparam logic [4:0] S_CLR  = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_PRE  = 5'd2;
    localparam logic [4:0] S_SEL  = 5'd3;
    localparam logic [4:0] S_RB0  = 5'd4;
    localparam logic [4:0] S_RB1  = 5'd5;
    localparam logic [4:0] S_RB2  = 5'd6;
    localparam logic [4:0] S_RA1  = 5'd7;
    localparam logic [4:0] S_RA2  = 5'd8;
    localparam logic [4:0] S_Y    = 5'd9;
    localparam logic [4:0] S_W1   = 5'd10;
    localparam logic [4:0] S_W2   = 5'd11;
    localparam logic [4:0] S_W2B  = 5'd12;
    localparam logic [4:0] S_OUT  = 5'd13;
    localparam logic [4:0] S_GAIN = 5'd14;
    localparam logic [4:0] S_DONE = 5'd15;
    localparam logic [4:0] S_PRE2 = 5'd16;

    t_cfg r_cfg;
    logic [4:0] r_st;
    logic [CLR_W-1:0] r_clr;
    logic [SW-1:0] r_stage;
    logic r_ch;
    logic [2:0] r_k;
    logic r_coob;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [SAMPLE_BITS-1:0] r_res [2];
    logic [15:0] r_in [2];
    logic r_last;
    logic signed [COEF_W-1:0] r_c [5];
    logic signed [ACC_W-1:0] r_w1, r_w2, r_y;
    logic signed [ACC_W+3:0] r_acc;
    logic signed [COEF_W+SAMPLE_BITS-1:0] r_p;
    logic r_ovalid;
    logic [31:0] r_odata;
    logic r_olast;

    logic cm_we, dm_we;
    logic [COEF_AW-1:0] cm_wa, cm_ra;
    logic signed [COEF_W-1:0] cm_wd, cm_rd;
    logic [DAW-1:0] dm_wa, dm_ra;
    logic signed [ACC_W-1:0] dm_wd, dm_rd;

    seq_coef_mem u_coef (
        .i_clk(i_clk), .i_we(cm_we), .i_waddr(cm_wa), .i_wdata(cm_wd),
        .i_raddr(cm_ra), .o_rdata(cm_rd)
    );
    seq_delay_mem #(.DEPTH(DDEPTH), .AW(DAW)) u_delay (
        .i_clk(i_clk), .i_we(dm_we), .i_waddr(dm_wa), .i_wdata(dm_wd),
        .i_raddr(dm_ra), .o_rdata(dm_rd)
    );

    logic in_fire;
    assign s_axis_tready = (r_st == S_IDLE);
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    // coefficient address: stage*5+k, beyond memory reads zero
    logic [SW+3:0] cidx;
    logic c_oob;
    assign cidx  = (SW+4)'(r_stage) * (SW+4)'(5) + (SW+4)'(r_k);
    assign c_oob = cidx >= (SW+4)'(COEF_DEPTH);
    logic [DAW-1:0] dbase;
    assign dbase = DAW'(((DAW+1)'(r_stage) * (DAW+1)'(2) + (DAW+1)'(r_ch)) * (DAW+1)'(2));

    logic band_on;
    always_comb begin
        band_on = 1'b0;
        if (32'(r_stage) < ENABLE_BITS && 32'(r_stage) < NUM_BANDS)
            band_on = r_cfg.band_en[4'(r_stage)];
    end

    // floor(c*y/2^28) split: yh=y>>>28 (28 bits), yl=y[27:0]
    logic signed [ACC_W-FRAC-1:0] yh;
    logic [FRAC-1:0] yl;
    assign yh = r_y[ACC_W-1:FRAC];
    assign yl = r_y[FRAC-1:0];
    logic signed [COEF_W-1:0] cur_c;
    assign cur_c = (r_st == S_W2 || r_st == S_W2B) ? r_c[4] : r_c[3];

    logic signed [COEF_W+FRAC:0] pl;
    logic signed [COEF_W+ACC_W-FRAC-1:0] ph;
    assign pl = cur_c * $signed({1'b0, yl});
    assign ph = cur_c * yh;

    logic [15:0] sw;
    always_comb begin
        sw = r_cfg.byteswap ? {r_in[r_ch][7:0], r_in[r_ch][15:8]} : r_in[r_ch];
    end
    logic signed [25:0] pre_p;
    assign pre_p = 26'($signed(sw)) * $signed({18'd0, r_cfg.preamp});

    logic signed [SAMPLE_BITS-1:0] smax, smin;
    assign smax = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    assign smin = ~smax;

    logic signed [ACC_W-1:0] ytr;
    assign ytr = (r_y < 0) ? (r_y + $signed(ACC_W'(((64'd1) << FRAC) - 1))) >>> FRAC
                           : r_y >>> FRAC;

    // gain: |y| * g / 2^42, product registered in S_OUT, shifted and saturated in S_GAIN
    logic [ACC_W-1:0] mag;
    assign mag = r_y[ACC_W-1] ? ACC_W'(-r_y) : r_y;
    logic [15:0] gsel;
    assign gsel = r_ch ? r_cfg.rgain : r_cfg.lgain;
    logic [ACC_W+15:0] gq;
    logic signed [ACC_W+16:0] gsg;

    logic [ACC_W+15:0] r_gp;
    logic r_gneg;
    assign gq = r_gp >> 42;
    assign gsg = r_gneg ? -$signed({1'b0, gq}) : $signed({1'b0, gq});

    logic signed [SAMPLE_BITS-1:0] sat_gain, sat_tr;
    always_comb begin
        if (gsg > (ACC_W+17)'(smax)) sat_gain = smax;
        else if (gsg < (ACC_W+17)'(smin)) sat_gain = smin;
        else sat_gain = gsg[SAMPLE_BITS-1:0];
        if (ytr > ACC_W'(smax)) sat_tr = smax;
        else if (ytr < ACC_W'(smin)) sat_tr = smin;
        else sat_tr = ytr[SAMPLE_BITS-1:0];
    end
    logic signed [SAMPLE_BITS-1:0] sat_pre;
    logic signed [25:0] pre_sh;
    assign pre_sh = pre_p >>> 6;
    always_comb begin
        if (pre_sh > 26'(smax)) sat_pre = smax;
        else if (pre_sh < 26'(smin)) sat_pre = smin;
        else sat_pre = pre_sh[SAMPLE_BITS-1:0];
    end

    always_comb begin
        cm_we = 1'b0; cm_wa = cidx[COEF_AW-1:0]; cm_wd = '0; cm_ra = cidx[COEF_AW-1:0];
        dm_we = 1'b0; dm_wa = dbase; dm_wd = '0; dm_ra = dbase;
        if (r_st == S_CLR) begin
            cm_we = 1'b1; cm_wa = r_clr[COEF_AW-1:0];
            dm_we = (32'(r_clr) < DDEPTH); dm_wa = DAW'(r_clr);
        end else if (in_fire && s_axis_tuser == CMD_COEF) begin
            cm_we = 1'b1; cm_wa = s_axis_tdata[37:32]; cm_wd = s_axis_tdata[69:38];
        end
        if (r_st == S_RB1) dm_ra = dbase + DAW'(1);
        if (r_st == S_W1) begin
            dm_we = 1'b1; dm_wd = sat56(r_acc);
        end
        if (r_st == S_W2B) begin
            dm_we = 1'b1; dm_wa = dbase + DAW'(1); dm_wd = sat56(r_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR; r_clr <= '0; r_ovalid <= 1'b0;
            r_cfg <= '{byteswap: 1'b0, preamp: 8'd64, band_en: 10'd0,
                       lgain: 16'd16384, rgain: 16'd16384};
            r_stage <= '0; r_ch <= 1'b0; r_k <= '0;
        end else begin
            r_coob <= c_oob;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_BYTESWAP: r_cfg.byteswap <= i_cfg_wdata[0];
                    REG_PREAMP:   r_cfg.preamp   <= i_cfg_wdata[7:0];
                    REG_BANDEN:   r_cfg.band_en  <= i_cfg_wdata[9:0];
                    REG_LGAIN:    r_cfg.lgain    <= i_cfg_wdata;
                    REG_RGAIN:    r_cfg.rgain    <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (r_ovalid && m_axis_tready && r_st != S_DONE) r_ovalid <= 1'b0;
            unique case (r_st)
                S_CLR: begin
                    r_clr <= r_clr + CLR_W'(1);
                    if (32'(r_clr) == CLR_N - 1) r_st <= S_IDLE;
                end
                S_IDLE: begin
                    if (in_fire && s_axis_tuser == CMD_SAMPLE) begin
                        r_in[0] <= s_axis_tdata[15:0];
                        r_in[1] <= s_axis_tdata[31:16];
                        r_last <= s_axis_tlast;
                        r_ch <= 1'b0;
                        r_st <= S_PRE;
                    end
                end
                S_PRE: begin
                    r_x <= sat_pre; r_stage <= '0; r_k <= '0;
                    r_st <= S_SEL;
                end
                S_SEL: begin
                    if (32'(r_stage) < NUM_BANDS && !band_on)
                        r_stage <= r_stage + SW'(1);
                    else begin
                        r_k <= 3'd0; r_st <= S_RB0;
                    end
                end
                S_RB0: begin r_k <= 3'd1; r_st <= S_RB1; end
                S_RB1: begin
                    r_c[0] <= r_coob ? '0 : cm_rd; r_w1 <= dm_rd;
                    r_k <= 3'd2; r_st <= S_RB2;
                end
                S_RB2: begin
                    r_c[1] <= r_coob ? '0 : cm_rd; r_w2 <= dm_rd;
                    r_k <= 3'd3; r_st <= S_RA1;
                end
                S_RA1: begin
                    r_c[2] <= r_coob ? '0 : cm_rd;
                    r_k <= 3'd4; r_st <= S_RA2;
                end
                S_RA2: begin
                    r_c[3] <= r_coob ? '0 : cm_rd;
                    r_p <= r_c[0] * r_x;
                    r_st <= S_Y;
                end
                S_Y: begin
                    r_c[4] <= r_coob ? '0 : cm_rd;
                    r_y <= sat56((ACC_W+4)'(r_p) + (ACC_W+4)'(r_w1));
                    r_p <= r_c[1] * r_x;
                    r_st <= S_PRE2;
                end
                S_PRE2: begin
                    r_acc <= (ACC_W+4)'(r_p) + (ACC_W+4)'(r_w2)
                           + (ACC_W+4)'(ph) + (ACC_W+4)'(pl >>> FRAC);
                    r_p <= r_c[2] * r_x;
                    r_st <= S_W1;
                end
                S_W1: begin
                    r_st <= S_W2;
                end
                S_W2: begin
                    r_acc <= (ACC_W+4)'(r_p) + (ACC_W+4)'(ph) + (ACC_W+4)'(pl >>> FRAC);
                    r_st <= S_W2B;
                end
                S_W2B: r_st <= S_OUT;
                S_OUT: begin
                    if (32'(r_stage) < NUM_BANDS) begin
                        r_x <= sat_tr; r_stage <= r_stage + SW'(1); r_st <= S_SEL;
                    end else begin
                        r_gp <= (ACC_W+16)'(mag) * (ACC_W+16)'(gsel);
                        r_gneg <= r_y[ACC_W-1];
                        r_st <= S_GAIN;
                    end
                end
                S_GAIN: begin
                    r_res[r_ch] <= sat_gain;
                    if (!r_ch) begin
                        r_ch <= 1'b1; r_st <= S_PRE;
                    end else r_st <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata <= {16'(r_res[1]), 16'(r_res[0])};
                        r_olast <= r_last;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata)) else $error("out moved");
    a_clr_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_CLR) |-> !m_axis_tvalid) else $error("output in clear");
`endif
endmodule
`default_nettype wire

/* bench/eq_checker.sv */
`default_nettype none
module eq_checker
    import seq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    input  wire logic              s_axis_tready,
    input  wire logic [71:0]       s_axis_tdata,
    input  wire logic              s_axis_tuser,
    input  wire logic              s_axis_tlast,
    input  wire logic              m_axis_tvalid,
    input  wire logic              m_axis_tready,
    input  wire logic [31:0]       m_axis_tdata,
    input  wire logic              m_axis_tlast,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_AW-1:0] i_cfg_addr,
    input  wire logic [CFG_DW-1:0] i_cfg_wdata,
    output int                     o_errors,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] t_wide;
    typedef struct packed {
        logic [15:0] left;
        logic [15:0] right;
        logic        last;
    } t_eq_out;

    t_eq_out               out_q[$];
    t_cfg                  cfg;
    logic signed [31:0]    coef_tab[COEF_DEPTH];
    logic signed [55:0]    delay_tab[(NUM_BANDS_DEF+1)*4];

    function automatic t_wide clamp(t_wide v, int bits);
        t_wide lim;
        lim = t_wide'(1) <<< (bits - 1);
        if (v > lim - 1) return lim - 1;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic t_wide coef_at(int st, int k);
        int idx;
        idx = st * 5 + k;
        if (idx < COEF_DEPTH) return t_wide'(coef_tab[idx]);
        return 0;
    endfunction

    function automatic t_wide to_int(t_wide y);
        if (y >= 0) return y >>> FRAC;
        return -((-y) >>> FRAC);
    endfunction

    task automatic biquad(input int st, input int ch, input t_wide x, output t_wide y);
        int d;
        t_wide w1;
        t_wide w2;
        d = (st * 2 + ch) * 2;
        w1 = delay_tab[d];
        w2 = delay_tab[d+1];
        y = clamp(coef_at(st, 0) * x + w1, ACC_W);
        delay_tab[d] = 56'(clamp(coef_at(st, 1) * x + ((coef_at(st, 3) * y) >>> FRAC) + w2,
                                 ACC_W));
        delay_tab[d+1] = 56'(clamp(coef_at(st, 2) * x + ((coef_at(st, 4) * y) >>> FRAC),
                                   ACC_W));
    endtask

    task automatic filter_channel(input int ch, input logic [15:0] word,
                                  input logic [15:0] gain, output logic [15:0] res);
        logic signed [15:0] sw;
        t_wide s;
        t_wide y;
        t_wide m;
        t_wide g;
        t_wide q;
        sw = cfg.byteswap ? {word[7:0], word[15:8]} : word;
        s = sw;
        s = clamp((s * t_wide'(cfg.preamp)) >>> 6, SAMPLE_BITS_DEF);
        for (int b = 0; b < NUM_BANDS_DEF; b++) begin
            if (b < ENABLE_BITS && cfg.band_en[b]) begin
                biquad(b, ch, s, y);
                s = clamp(to_int(y), SAMPLE_BITS_DEF);
            end
        end
        biquad(NUM_BANDS_DEF, ch, s, y);
        g = t_wide'(gain);
        m = (y < 0) ? -y : y;
        q = (m * g) >>> (FRAC + 14);
        if (y < 0) q = -q;
        res = 16'(clamp(q, SAMPLE_BITS_DEF));
    endtask

    task automatic report(input string what, input logic [15:0] want, input logic [15:0] got);
        $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
        cfg = '{byteswap: 1'b0, preamp: 8'd64, band_en: 10'd0, lgain: 16'd16384,
                rgain: 16'd16384};
        foreach (coef_tab[i]) coef_tab[i] = '0;
        foreach (delay_tab[i]) delay_tab[i] = '0;
    end

    always @(posedge i_clk) begin
        t_eq_out e;
        t_eq_out got;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_BYTESWAP: cfg.byteswap = i_cfg_wdata[0];
                    REG_PREAMP:   cfg.preamp   = i_cfg_wdata[7:0];
                    REG_BANDEN:   cfg.band_en  = i_cfg_wdata[9:0];
                    REG_LGAIN:    cfg.lgain    = i_cfg_wdata;
                    REG_RGAIN:    cfg.rgain    = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == CMD_COEF) begin
                    coef_tab[s_axis_tdata[37:32]] = s_axis_tdata[69:38];
                end else begin
                    filter_channel(0, s_axis_tdata[15:0], cfg.lgain, e.left);
                    filter_channel(1, s_axis_tdata[31:16], cfg.rgain, e.right);
                    e.last = s_axis_tlast;
                    out_q.push_back(e);
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tlast};
                if (out_q.size() == 0) begin
                    report("unexpected beat", 16'h0000, m_axis_tdata[15:0]);
                end else begin
                    e = out_q.pop_front();
                    if (got.left !== e.left) report("left", e.left, got.left);
                    if (got.right !== e.right) report("right", e.right, got.right);
                    if (got.last !== e.last) report("tlast", 16'(e.last), 16'(got.last));
                end
            end
            o_pending = out_q.size();
        end
    end
endmodule
`default_nettype wire

/* bench/tb_top.sv */
`default_nettype none
module tb_top;
    import seq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int DRAIN       = 400;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [71:0]       s_axis_tdata = '0;
    logic              s_axis_tuser = 1'b0;
    logic              s_axis_tlast = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [31:0]       m_axis_tdata;
    logic              m_axis_tlast;
    logic              i_cfg_we = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr = '0;
    logic [CFG_DW-1:0] i_cfg_wdata = '0;
    int                errors;
    int                pending;
    int                cycles = 0;
    bit                calm = 1'b0;

    always #5 i_clk = ~i_clk;

    stereo_eq_lowpass_chain u_top (.*);

    eq_checker u_chk (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .s_axis_tlast, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
        .i_cfg_we, .i_cfg_addr, .i_cfg_wdata, .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            n = pick_gap();
            if (n > 0) begin
                m_axis_tready = 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // hold each beat until accepted; valid stays high into the next beat when no gap
    task automatic send_beat(input logic cmd, input logic [15:0] l, input logic [15:0] r,
                             input logic [5:0] ci, input logic [31:0] cv, input logic last);
        int n;
        n = pick_gap();
        if (n > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (n) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = {2'b00, cv, ci, r, l};
        s_axis_tlast  = last;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic send_coef(input logic [5:0] ci, input logic [31:0] cv);
        send_beat(CMD_COEF, 16'($urandom), 16'($urandom), ci, cv, 1'($urandom));
    endtask

    task automatic send_pair(input logic [15:0] l, input logic [15:0] r, input logic last);
        send_beat(CMD_SAMPLE, l, r, 6'($urandom), $urandom, last);
    endtask

    task automatic cfg_write(input logic [CFG_AW-1:0] a, input logic [CFG_DW-1:0] d);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = a;
        i_cfg_wdata = d;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic wait_idle();
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coef(int k);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return $urandom;
        if (r < 12) return 32'h0;
        if (k == 0) return 32'(32'sd268435456 + $signed($urandom_range(0, 1 << 27)) - (1 << 26));
        return 32'($signed($urandom_range(0, 1 << 27)) - (1 << 26));
    endfunction

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] pre;
        logic [15:0] ban;
        logic [15:0] lg;
        logic [15:0] rg;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset defaults, then passthrough lowpass with extremes
        send_pair(16'h7fff, 16'h8000, 1'b1);
        send_coef(6'd50, 32'h1000_0000);
        send_coef(6'd63, 32'hdead_beef);
        send_coef(6'd55, 32'h7fff_ffff);
        send_pair(16'h7fff, 16'h8000, 1'b0);
        send_pair(16'h0000, 16'hffff, 1'b1);
        send_pair(16'h0080, 16'h7f00, 1'b0);
        send_coef(6'd0, 32'h7fff_ffff);
        send_coef(6'd1, 32'h8000_0000);
        send_coef(6'd3, 32'h8000_0000);
        send_coef(6'd4, 32'h7fff_ffff);
        wait_idle();
        cfg_write(REG_BYTESWAP, 16'hffff);
        cfg_write(REG_PREAMP, 16'h00ff);
        cfg_write(REG_BANDEN, 16'h03ff);
        cfg_write(REG_LGAIN, 16'hffff);
        cfg_write(REG_RGAIN, 16'h0000);
        cfg_write(3'd7, 16'h1234);
        send_pair(16'h7fff, 16'h0080, 1'b1);
        send_pair(16'h8000, 16'hff7f, 1'b0);
        send_pair(16'h0100, 16'h0000, 1'b1);
        wait_idle();
        cfg_write(REG_BYTESWAP, 16'h0000);
        cfg_write(REG_PREAMP, 16'h0000);
        cfg_write(REG_BANDEN, 16'h0001);
        cfg_write(REG_LGAIN, 16'h0000);
        cfg_write(REG_RGAIN, 16'hffff);
        send_pair(16'h7fff, 16'h8000, 1'b0);
        send_pair(16'h1234, 16'hedcb, 1'b1);

        for (int p = 0; p < 11; p++) begin
            wait_idle();
            calm = ($urandom_range(0, 3) == 0);
            case (p)
                0: begin pre = 16'd64;  ban = 16'h0000; lg = 16'd16384; rg = 16'd16384; end
                1: begin pre = 16'd255; ban = 16'h03ff; lg = 16'hffff;  rg = 16'hffff;  end
                2: begin pre = 16'd0;   ban = 16'h03ff; lg = 16'h0000;  rg = 16'h0001;  end
                default: begin
                    pre = 16'($urandom);
                    ban = 16'($urandom);
                    lg = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
                    rg = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
                end
            endcase
            cfg_write(REG_BYTESWAP, 16'($urandom));
            cfg_write(REG_PREAMP, pre);
            cfg_write(REG_BANDEN, ban);
            cfg_write(REG_LGAIN, lg);
            cfg_write(REG_RGAIN, rg);
            if (p < 2 || $urandom_range(0, 1) == 0) begin
                for (int i = 0; i < COEF_DEPTH; i++) send_coef(6'(i), rand_coef(i % 5));
            end
            for (int i = 0; i < 80; i++) begin
                if ($urandom_range(0, 9) == 0)
                    send_coef(6'($urandom), rand_coef($urandom_range(0, 4)));
                else
                    send_pair(rand_sample(), rand_sample(), ($urandom_range(0, 7) == 0));
            end
        end

        wait_idle();
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
